// ----- rtl/core/spd_pkg.sv -----
// Shared types and constants for the sparse profile distance block.
`default_nettype none
package spd_pkg;

   localparam int ACC_W   = 48;
   localparam int CNT_W   = 16;
   localparam int SEQ_W   = 10;
   localparam int STEP_W  = 7;

   localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};
   localparam logic [ACC_W-1:0] Q_ONE   = 48'd65536;

   localparam logic [STEP_W-1:0] MUL_LAST  = 7'd47;
   localparam logic [STEP_W-1:0] SQRT_LAST = 7'd47;
   localparam logic [STEP_W-1:0] DIV_LAST  = 7'd63;

   localparam logic [1:0] MET_L1   = 2'd0;
   localparam logic [1:0] MET_L2   = 2'd1;
   localparam logic [1:0] MET_COS  = 2'd2;
   localparam logic [1:0] MET_JAC  = 2'd3;

   localparam logic [1:0] STAT_OK   = 2'd0;
   localparam logic [1:0] STAT_ZERO = 2'd1;
   localparam logic [1:0] STAT_SAT  = 2'd2;

   // One finished pair as handed from the accumulator to the evaluator.
   // L1: op_a abs sum. L2: op_a squared sum.
   // Cosine: op_a dot, op_b norm_first, op_c norm_second.
   // Jaccard: op_a min sum, op_b total_first, op_c total_second.
   typedef struct packed {
      logic [1:0]       metric;
      logic             sat;
      logic [SEQ_W-1:0] pair_first;
      logic [SEQ_W-1:0] pair_second;
      logic [ACC_W-1:0] op_a;
      logic [ACC_W-1:0] op_b;
      logic [ACC_W-1:0] op_c;
   } rec_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_JSUM,
      S_JSUB,
      S_MUL,
      S_SQRT,
      S_DIV,
      S_FIN
   } back_state_type;

endpackage
`default_nettype wire

// ----- rtl/core/spd_front.sv -----
// Front end: takes key items, updates the eight saturating accumulators.
`default_nettype none
module spd_front (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    take,
   input  wire logic [9:0]              seq_first,
   input  wire logic [9:0]              seq_second,
   input  wire logic [15:0]             count_first,
   input  wire logic [15:0]             count_second,
   input  wire logic                    final_key,
   input  wire logic [1:0]              metric,
   output logic                         rec_push,
   output spd_pkg::rec_type             rec
);
   import spd_pkg::*;

   logic [ACC_W-1:0] acc_ff [8];
   logic [ACC_W-1:0] acc_in [8];
   logic [ACC_W-1:0] add_v  [8];
   logic [7:0]       sat_ff, sat_in;
   logic [CNT_W-1:0] diff, mn;
   logic [2*CNT_W-1:0] sq, dot, na, nb;
   logic [ACC_W:0]   sum;
   logic [7:0]       need;

   always_comb begin
      diff = (count_first > count_second) ? count_first - count_second
                                          : count_second - count_first;
      mn   = (count_first < count_second) ? count_first : count_second;
      sq   = diff * diff;
      dot  = count_first * count_second;
      na   = count_first * count_first;
      nb   = count_second * count_second;
      add_v[0] = {32'd0, diff};
      add_v[1] = {16'd0, sq};
      add_v[2] = {16'd0, dot};
      add_v[3] = {16'd0, na};
      add_v[4] = {16'd0, nb};
      add_v[5] = {32'd0, mn};
      add_v[6] = {32'd0, count_first};
      add_v[7] = {32'd0, count_second};
      sat_in = sat_ff;
      for (int i = 0; i < 8; i++) begin
         sum = {1'b0, acc_ff[i]} + {1'b0, add_v[i]};
         if (sum[ACC_W]) begin
            acc_in[i] = ACC_MAX;
            sat_in[i] = 1'b1;
         end else begin
            acc_in[i] = sum[ACC_W-1:0];
         end
      end
   end

   always_comb begin
      case (metric)
         MET_L1:  need = 8'h01;
         MET_L2:  need = 8'h02;
         MET_COS: need = 8'h1c;
         default: need = 8'he0;
      endcase
      rec.metric      = metric;
      rec.sat         = |(sat_in & need);
      rec.pair_first  = seq_first;
      rec.pair_second = seq_second;
      rec.op_b        = '0;
      rec.op_c        = '0;
      case (metric)
         MET_L1:  rec.op_a = acc_in[0];
         MET_L2:  rec.op_a = acc_in[1];
         MET_COS: begin
            rec.op_a = acc_in[2];
            rec.op_b = acc_in[3];
            rec.op_c = acc_in[4];
         end
         default: begin
            rec.op_a = acc_in[5];
            rec.op_b = acc_in[6];
            rec.op_c = acc_in[7];
         end
      endcase
      rec_push = take && final_key;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sat_ff <= '0;
         for (int i = 0; i < 8; i++) acc_ff[i] <= '0;
      end else if (take) begin
         if (final_key) begin
            sat_ff <= '0;
            for (int i = 0; i < 8; i++) acc_ff[i] <= '0;
         end else begin
            sat_ff <= sat_in;
            for (int i = 0; i < 8; i++) acc_ff[i] <= acc_in[i];
         end
      end
   end

endmodule
`default_nettype wire

// ----- rtl/core/spd_queue.sv -----
// Two-entry queue of finished pairs between the front and the back end.
`default_nettype none
module spd_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire spd_pkg::rec_type  wr,
   input  wire logic              pop,
   output spd_pkg::rec_type       rd,
   output logic                   empty,
   output logic                   full
);
   import spd_pkg::*;

   rec_type    slot_ff [2];
   logic [1:0] cnt_ff;

   assign rd    = slot_ff[0];
   assign empty = (cnt_ff == 2'd0);
   assign full  = (cnt_ff == 2'd2);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         slot_ff[0] <= slot_ff[1];
         if (push && cnt_ff == 2'd1) slot_ff[0] <= wr;
         if (push && cnt_ff == 2'd2) slot_ff[1] <= wr;
      end else if (push) begin
         if (cnt_ff == 2'd0) slot_ff[0] <= wr;
         else slot_ff[1] <= wr;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/core/spd_back.sv -----
// Back end: serial multiply, square root and divide, plus the result register.
`default_nettype none
module spd_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire spd_pkg::rec_type  rec,
   input  wire logic              rec_empty,
   output logic                   rec_pop,
   output logic                   rsp_empty,
   input  wire logic              rsp_pop,
   output logic [9:0]             rsp_pair_first,
   output logic [9:0]             rsp_pair_second,
   output logic [47:0]            rsp_distance,
   output logic [1:0]             rsp_status
);
   import spd_pkg::*;

   back_state_type st_ff, st_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [1:0]   met_ff, met_in;
   logic [SEQ_W-1:0] pf_ff, pf_in, ps_ff, ps_in;
   logic [95:0]  mc_ff, mc_in, prod_ff, prod_in;
   logic [47:0]  mp_ff, mp_in, keep_ff, keep_in, root_ff, root_in;
   logic [51:0]  rem_ff, rem_in;
   logic [48:0]  den_ff, den_in;
   logic [63:0]  num_ff, num_in, quo_ff, quo_in;
   logic [47:0]  dist_ff, dist_in;
   logic [1:0]   stat_ff, stat_in;
   logic         out_v_ff;
   logic         out_free;
   logic [51:0]  trial, rs;
   logic [50:0]  rd;
   logic [63:0]  qc;

   assign out_free = !out_v_ff || rsp_pop;
   assign rsp_empty = !out_v_ff;

   // Next state.
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         S_IDLE: begin
            if (!rec_empty) begin
               if (rec.sat || rec.metric == MET_L1) st_in = S_FIN;
               else if (rec.metric == MET_L2) st_in = S_SQRT;
               else if (rec.metric == MET_COS) begin
                  if (rec.op_b == '0 || rec.op_c == '0) st_in = S_FIN;
                  else st_in = S_MUL;
               end else st_in = S_JSUM;
            end
         end
         S_JSUM: st_in = S_JSUB;
         S_JSUB: st_in = ({1'b0, keep_ff} >= den_ff) ? S_FIN : S_DIV;
         S_MUL:  if (cnt_ff == MUL_LAST) st_in = S_SQRT;
         S_SQRT: begin
            if (cnt_ff == SQRT_LAST) st_in = (met_ff == MET_COS) ? S_DIV : S_FIN;
         end
         S_DIV:  if (cnt_ff == DIV_LAST) st_in = S_FIN;
         S_FIN:  if (out_free) st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
   end

   // Datapath.
   always_comb begin
      cnt_in  = cnt_ff;
      met_in  = met_ff;
      pf_in   = pf_ff;
      ps_in   = ps_ff;
      mc_in   = mc_ff;
      mp_in   = mp_ff;
      prod_in = prod_ff;
      keep_in = keep_ff;
      root_in = root_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      num_in  = num_ff;
      quo_in  = quo_ff;
      dist_in = dist_ff;
      stat_in = stat_ff;
      rec_pop = 1'b0;
      trial   = {2'b00, root_ff, 2'b01};
      rs      = {rem_ff[49:0], prod_ff[95:94]};
      rd      = {rem_ff[49:0], num_ff[63]};
      qc      = '0;
      case (st_ff)
         S_IDLE: begin
            if (!rec_empty) begin
               rec_pop = 1'b1;
               met_in  = rec.metric;
               pf_in   = rec.pair_first;
               ps_in   = rec.pair_second;
               keep_in = rec.op_a;
               cnt_in  = '0;
               rem_in  = '0;
               root_in = '0;
               quo_in  = '0;
               stat_in = STAT_OK;
               dist_in = '0;
               prod_in = {16'd0, rec.op_a, 32'd0};
               mc_in   = {48'd0, rec.op_b};
               mp_in   = rec.op_c;
               den_in  = {1'b0, rec.op_b} + {1'b0, rec.op_c};
               if (rec.sat) begin
                  stat_in = STAT_SAT;
                  dist_in = ACC_MAX;
               end else if (rec.metric == MET_L1) begin
                  if (rec.op_a[47:32] != '0) begin
                     stat_in = STAT_SAT;
                     dist_in = ACC_MAX;
                  end else begin
                     dist_in = {rec.op_a[31:0], 16'd0};
                  end
               end else if (rec.metric == MET_COS) begin
                  prod_in = '0;
                  if (rec.op_b == '0 || rec.op_c == '0) stat_in = STAT_ZERO;
               end
            end
         end
         S_JSUM: ;
         S_JSUB: begin
            if ({1'b0, keep_ff} >= den_ff) begin
               stat_in = STAT_ZERO;
            end else begin
               den_in = den_ff - {1'b0, keep_ff};
               num_in = {keep_ff, 16'd0};
               cnt_in = '0;
            end
         end
         S_MUL: begin
            if (mp_ff[0]) prod_in = prod_ff + mc_ff;
            mc_in  = {mc_ff[94:0], 1'b0};
            mp_in  = {1'b0, mp_ff[47:1]};
            cnt_in = (cnt_ff == MUL_LAST) ? '0 : cnt_ff + 1'b1;
         end
         S_SQRT: begin
            prod_in = {prod_ff[93:0], 2'b00};
            if (rs >= trial) begin
               rem_in  = rs - trial;
               root_in = {root_ff[46:0], 1'b1};
            end else begin
               rem_in  = rs;
               root_in = {root_ff[46:0], 1'b0};
            end
            cnt_in = (cnt_ff == SQRT_LAST) ? '0 : cnt_ff + 1'b1;
            if (cnt_ff == SQRT_LAST) begin
               dist_in = root_in;
               den_in  = {1'b0, root_in};
               num_in  = {keep_ff, 16'd0};
               rem_in  = '0;
            end
         end
         S_DIV: begin
            num_in = {num_ff[62:0], 1'b0};
            if (rd >= {2'b00, den_ff}) begin
               rem_in = {1'b0, rd - {2'b00, den_ff}};
               quo_in = {quo_ff[62:0], 1'b1};
            end else begin
               rem_in = {1'b0, rd};
               quo_in = {quo_ff[62:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) begin
               qc = (quo_in > {16'd0, Q_ONE}) ? {16'd0, Q_ONE} : quo_in;
               dist_in = Q_ONE - qc[47:0];
            end
         end
         S_FIN: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= S_IDLE;
         out_v_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         if (st_ff == S_FIN && out_free) out_v_ff <= 1'b1;
         else if (rsp_pop) out_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      met_ff  <= met_in;
      pf_ff   <= pf_in;
      ps_ff   <= ps_in;
      mc_ff   <= mc_in;
      mp_ff   <= mp_in;
      prod_ff <= prod_in;
      keep_ff <= keep_in;
      root_ff <= root_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      num_ff  <= num_in;
      quo_ff  <= quo_in;
      dist_ff <= dist_in;
      stat_ff <= stat_in;
      if (st_ff == S_FIN && out_free) begin
         rsp_pair_first  <= pf_ff;
         rsp_pair_second <= ps_ff;
         rsp_distance    <= dist_ff;
         rsp_status      <= stat_ff;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/core/sparse_profile_distance.sv -----
// A non-final key is absorbed into the accumulators. For L1 or a flagged case a pair result goes
// straight to the result stage; L2 runs the square root, Jaccard the divide, cosine all three.
// Keys are taken one per cycle while the queue is not full; pair results are limited by the serial
// multiply, square root and divide of the single back-end evaluator.
// Reset (synchronous, active high) clears the accumulators, the queue, the result valid flag
// and sets the metric register to L1.
`default_nettype none
module sparse_profile_distance (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [9:0]  req_seq_first,
   input  wire logic [9:0]  req_seq_second,
   input  wire logic [15:0] req_count_first,
   input  wire logic [15:0] req_count_second,
   input  wire logic        req_final_key,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [9:0]       rsp_pair_first,
   output logic [9:0]       rsp_pair_second,
   output logic [47:0]      rsp_distance,
   output logic [1:0]       rsp_status,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_wdata
);
   import spd_pkg::*;

   // The metric register is sampled by the front end when the final key of a pair
   // arrives, so each queued pair carries its own metric.
   logic [1:0] metric_ff;
   logic       take;
   logic       rec_push, rec_pop, q_empty, q_full;
   rec_type    rec_wr, rec_rd;

   always_ff @(posedge clock) begin
      if (reset) metric_ff <= MET_L1;
      else if (csr_we) metric_ff <= csr_wdata;
   end

   // Input is held off while the queue is full, so a final key always has a slot.
   assign req_full = q_full;
   assign take     = req_push && !q_full;

   spd_front u_front (
      .clock        (clock),
      .reset        (reset),
      .take         (take),
      .seq_first    (req_seq_first),
      .seq_second   (req_seq_second),
      .count_first  (req_count_first),
      .count_second (req_count_second),
      .final_key    (req_final_key),
      .metric       (metric_ff),
      .rec_push     (rec_push),
      .rec          (rec_wr)
   );

   // Short queue that decouples key intake from the slow per-pair evaluation.
   spd_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (rec_push),
      .wr    (rec_wr),
      .pop   (rec_pop),
      .rd    (rec_rd),
      .empty (q_empty),
      .full  (q_full)
   );

   // Evaluator and result register; a finished result waits there for its transfer
   // while the front end keeps accepting keys.
   spd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .rec             (rec_rd),
      .rec_empty       (q_empty),
      .rec_pop         (rec_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_pair_first  (rsp_pair_first),
      .rsp_pair_second (rsp_pair_second),
      .rsp_distance    (rsp_distance),
      .rsp_status      (rsp_status)
   );

endmodule
`default_nettype wire

// ----- dv/testbench.sv -----
// Self-checking testbench for the sparse profile distance block.
`default_nettype none
module testbench;
   import spd_pkg::*;

   // The slowest correct run is well below this. It allows about 1100 keys that each
   // wait out the longest sender gap, the longest receiver stall and the cosine back end,
   // plus the long receiver hold-off and the metric changes, taken several times.
   localparam int CYCLE_LIMIT = 1500000;
   // Longest back-end latency from the final key to its result, with margin.
   localparam int SETTLE_CYCLES = 200;
   localparam int LONG_HOLD = 600;

   // One key as it is offered on the input side. A directed row may carry the
   // result that the final key must give. Where it does not, the profile model decides.
   typedef struct {
      logic [1:0]       metric;
      logic [SEQ_W-1:0] seq_first;
      logic [SEQ_W-1:0] seq_second;
      logic [CNT_W-1:0] count_first;
      logic [CNT_W-1:0] count_second;
      logic             final_key;
      logic             typed;
      logic [ACC_W-1:0] distance;
      logic [1:0]       status;
   } key_row_type;

   // One finished pair as it should leave the block.
   typedef struct {
      logic [SEQ_W-1:0] pair_first;
      logic [SEQ_W-1:0] pair_second;
      logic [ACC_W-1:0] distance;
      logic [1:0]       status;
   } pair_result_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_push = 1'b0;
   logic              req_full;
   logic [SEQ_W-1:0]  req_seq_first = '0;
   logic [SEQ_W-1:0]  req_seq_second = '0;
   logic [CNT_W-1:0]  req_count_first = '0;
   logic [CNT_W-1:0]  req_count_second = '0;
   logic              req_final_key = 1'b0;
   logic              rsp_empty;
   logic              rsp_pop = 1'b0;
   logic [SEQ_W-1:0]  rsp_pair_first;
   logic [SEQ_W-1:0]  rsp_pair_second;
   logic [ACC_W-1:0]  rsp_distance;
   logic [1:0]        rsp_status;
   logic              csr_we = 1'b0;
   logic [1:0]        csr_wdata = '0;

   sparse_profile_distance dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_seq_first    (req_seq_first),
      .req_seq_second   (req_seq_second),
      .req_count_first  (req_count_first),
      .req_count_second (req_count_second),
      .req_final_key    (req_final_key),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_pair_first   (rsp_pair_first),
      .rsp_pair_second  (rsp_pair_second),
      .rsp_distance     (rsp_distance),
      .rsp_status       (rsp_status),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata)
   );

   always #6 clock = ~clock;

   // Profile model state: the metric register, the eight accumulators and one sticky
   // saturation flag per accumulator.
   logic [1:0]       model_metric;
   logic [ACC_W-1:0] sum_abs, sum_sq, sum_dot, sum_norm_a, sum_norm_b;
   logic [ACC_W-1:0] sum_min, sum_tot_a, sum_tot_b;
   logic [7:0]       sat_flags;

   pair_result_type pending_pairs[$];
   key_row_type     directed_rows[$];
   int              error_count = 0;
   int              keys_sent = 0;
   int              pairs_checked = 0;
   int              status_seen[3] = '{0, 0, 0};
   int              metric_pairs[4] = '{0, 0, 0, 0};
   int              cycle_count = 0;
   bit              zero_gap_stretch = 1'b0;

   // Saturating add into a 48-bit accumulator. The flag sticks until the pair ends.
   function automatic logic [ACC_W-1:0] add_clamped(input logic [ACC_W-1:0] acc,
                                                    input logic [63:0] addend,
                                                    input int flag_bit);
      logic [63:0] total;
      total = {16'd0, acc} + addend;
      if (total > {16'd0, ACC_MAX}) begin
         sat_flags[flag_bit] = 1'b1;
         return ACC_MAX;
      end
      return total[ACC_W-1:0];
   endfunction

   // Bitwise integer square root of a value of up to 128 bits.
   function automatic logic [63:0] root_floor(input logic [127:0] radicand);
      logic [63:0]  root;
      logic [63:0]  trial;
      logic [127:0] square;
      root = '0;
      for (int b = 63; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         square = {64'd0, trial} * {64'd0, trial};
         if (square <= radicand)
            root = trial;
      end
      return root;
   endfunction

   function automatic void clear_profile_sums();
      sum_abs = '0; sum_sq = '0; sum_dot = '0; sum_norm_a = '0; sum_norm_b = '0;
      sum_min = '0; sum_tot_a = '0; sum_tot_b = '0;
      sat_flags = '0;
   endfunction

   // Folds one key into the sums. For a final key it works out the distance of the pair
   // under the current metric and clears the sums again.
   function automatic bit fold_key(input key_row_type row, output pair_result_type res);
      logic [63:0]  a, b, diff, quot, den;
      logic [127:0] prod;
      logic [7:0]   needed;
      a = {48'd0, row.count_first};
      b = {48'd0, row.count_second};
      diff = (a > b) ? a - b : b - a;
      sum_abs    = add_clamped(sum_abs, diff, 0);
      sum_sq     = add_clamped(sum_sq, diff * diff, 1);
      sum_dot    = add_clamped(sum_dot, a * b, 2);
      sum_norm_a = add_clamped(sum_norm_a, a * a, 3);
      sum_norm_b = add_clamped(sum_norm_b, b * b, 4);
      sum_min    = add_clamped(sum_min, (a < b) ? a : b, 5);
      sum_tot_a  = add_clamped(sum_tot_a, a, 6);
      sum_tot_b  = add_clamped(sum_tot_b, b, 7);
      res = '{row.seq_first, row.seq_second, '0, STAT_OK};
      if (!row.final_key)
         return 1'b0;
      case (model_metric)
         MET_L1:  needed = 8'h01;
         MET_L2:  needed = 8'h02;
         MET_COS: needed = 8'h1c;
         default: needed = 8'he0;
      endcase
      // Saturation of any sum that the metric reads wins over everything else.
      if ((sat_flags & needed) != 0) begin
         res.status = STAT_SAT;
         res.distance = ACC_MAX;
      end else if (model_metric == MET_L1) begin
         if (sum_abs >= 48'h1_0000_0000) begin
            res.status = STAT_SAT;
            res.distance = ACC_MAX;
         end else begin
            res.distance = sum_abs << 16;
         end
      end else if (model_metric == MET_L2) begin
         prod = {48'd0, sum_sq, 32'd0};
         res.distance = root_floor(prod);
      end else if (model_metric == MET_COS) begin
         if (sum_norm_a == 0 || sum_norm_b == 0) begin
            res.status = STAT_ZERO;
         end else begin
            prod = {80'd0, sum_norm_a} * {80'd0, sum_norm_b};
            den = root_floor(prod);
            quot = {sum_dot, 16'd0} / den;
            if (quot > {16'd0, Q_ONE})
               quot = {16'd0, Q_ONE};
            res.distance = Q_ONE - quot[ACC_W-1:0];
         end
      end else begin
         // Weighted Jaccard: the union is both totals less the shared part.
         den = {16'd0, sum_tot_a} + {16'd0, sum_tot_b};
         if ({16'd0, sum_min} >= den) begin
            res.status = STAT_ZERO;
         end else begin
            den = den - {16'd0, sum_min};
            quot = {sum_min, 16'd0} / den;
            if (quot > {16'd0, Q_ONE})
               quot = {16'd0, Q_ONE};
            res.distance = Q_ONE - quot[ACC_W-1:0];
         end
      end
      clear_profile_sums();
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string field, input logic [63:0] got,
                                  input logic [63:0] want);
      error_count++;
      $display("mismatch in pair %0d, %s: got %0h, expected %0h", pairs_checked, field,
               got, want);
   endtask

   function automatic int draw_gap();
      if (zero_gap_stretch)
         return 0;
      return $urandom_range(0, 17);
   endfunction

   // Offers one key and waits for the transfer. The model sees the key once it is taken.
   task automatic send_key(input key_row_type row, input int gap);
      pair_result_type res;
      bit              has_result;
      req_push         <= 1'b1;
      req_seq_first    <= row.seq_first;
      req_seq_second   <= row.seq_second;
      req_count_first  <= row.count_first;
      req_count_second <= row.count_second;
      req_final_key    <= row.final_key;
      do @(posedge clock); while (req_full);
      keys_sent++;
      has_result = fold_key(row, res);
      if (has_result) begin
         if (row.typed) begin
            res.distance = row.distance;
            res.status = row.status;
         end
         pending_pairs.push_back(res);
         metric_pairs[model_metric]++;
      end
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Writes the metric only when the block is idle: every pair has come out and the
   // back end has had time to finish.
   task automatic set_metric(input logic [1:0] value);
      req_push <= 1'b0;
      @(posedge clock);
      while (pending_pairs.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      model_metric = value;
   endtask

   function automatic void add_row(input logic [1:0] metric, input int seq_a, input int seq_b,
                                   input int cnt_a, input int cnt_b, input bit fin,
                                   input bit typed, input logic [ACC_W-1:0] want_distance,
                                   input logic [1:0] stat);
      key_row_type row;
      row = '{metric, seq_a[SEQ_W-1:0], seq_b[SEQ_W-1:0], cnt_a[CNT_W-1:0],
              cnt_b[CNT_W-1:0], fin, typed, want_distance, stat};
      directed_rows.push_back(row);
   endfunction

   function automatic logic [CNT_W-1:0] draw_count();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         2:       return CNT_W'($urandom_range(0, 15));
         3:       return CNT_W'($urandom_range(0, 255));
         default: return CNT_W'($urandom);
      endcase
   endfunction

   // Random pairs of mostly short length with random counts. A few are long, and now
   // and then a stretch of keys goes in with no gaps at all.
   task automatic send_random_pairs(input logic [1:0] metric, input int keys);
      key_row_type row;
      int          left, pair_len;
      if (model_metric != metric)
         set_metric(metric);
      left = keys;
      while (left > 0) begin
         pair_len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                 : $urandom_range(1, 5);
         if (pair_len > left)
            pair_len = left;
         for (int k = 0; k < pair_len; k++) begin
            if ($urandom_range(0, 39) == 0)
               zero_gap_stretch = ~zero_gap_stretch;
            row = '{metric, SEQ_W'($urandom), SEQ_W'($urandom), draw_count(), draw_count(),
                    (k == pair_len - 1), 1'b0, '0, STAT_OK};
            send_key(row, draw_gap());
         end
         left -= pair_len;
      end
      zero_gap_stretch = 1'b0;
   endtask

   // Result side: each transfer is checked against the oldest expected pair.
   always @(posedge clock) begin
      pair_result_type want;
      if (!reset && !rsp_empty && rsp_pop) begin
         if (pending_pairs.size() == 0) begin
            error_count++;
            $display("unexpected pair result: first %0d second %0d distance %0h status %0d",
                     rsp_pair_first, rsp_pair_second, rsp_distance, rsp_status);
         end else begin
            want = pending_pairs.pop_front();
            if (rsp_pair_first !== want.pair_first)
               report_mismatch("pair_first", 64'(rsp_pair_first), 64'(want.pair_first));
            if (rsp_pair_second !== want.pair_second)
               report_mismatch("pair_second", 64'(rsp_pair_second), 64'(want.pair_second));
            if (rsp_distance !== want.distance)
               report_mismatch("distance", 64'(rsp_distance), 64'(want.distance));
            if (rsp_status !== want.status)
               report_mismatch("status", 64'(rsp_status), 64'(want.status));
            if (want.status <= STAT_SAT)
               status_seen[want.status]++;
         end
         pairs_checked++;
      end
   end

   // The receiver stalls for a random number of cycles before each transfer. Once, early
   // in the random part, it holds off for a long stretch so that the block backs up.
   initial begin
      int  stall;
      bit  held;
      held = 1'b0;
      @(negedge reset);
      forever begin
         if (!held && pairs_checked >= 40) begin
            held = 1'b1;
            stall = LONG_HOLD;
         end else begin
            stall = zero_gap_stretch ? 0 : $urandom_range(0, 17);
         end
         if (stall > 0) begin
            rsp_pop <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles with %0d pairs outstanding", cycle_count,
                  pending_pairs.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      model_metric = MET_L1;
      clear_profile_sums();

      // Directed rows. Results that follow at a glance are typed in; the rest come from
      // the model. After reset the metric is L1.
      add_row(MET_L1, 0, 0, 0, 0, 1, 1, 48'd0, STAT_OK);
      add_row(MET_L1, 1023, 1023, 65535, 0, 1, 1, 48'hffff_0000, STAT_OK);
      add_row(MET_L1, 512, 1, 0, 65535, 0, 0, '0, STAT_OK);
      add_row(MET_L1, 512, 1, 65535, 65535, 1, 1, 48'hffff_0000, STAT_OK);
      add_row(MET_L1, 341, 682, 123, 45, 1, 0, '0, STAT_OK);
      add_row(MET_L2, 7, 9, 3, 0, 1, 1, 48'h3_0000, STAT_OK);
      add_row(MET_L2, 2, 3, 65535, 0, 0, 0, '0, STAT_OK);
      add_row(MET_L2, 2, 3, 1, 2, 1, 0, '0, STAT_OK);
      // Cosine with one empty profile has no denominator.
      add_row(MET_COS, 4, 5, 0, 5, 1, 1, 48'd0, STAT_ZERO);
      add_row(MET_COS, 4, 6, 7, 7, 1, 1, 48'd0, STAT_OK);
      add_row(MET_COS, 8, 9, 1, 0, 0, 0, '0, STAT_OK);
      add_row(MET_COS, 8, 9, 0, 1, 1, 1, 48'h1_0000, STAT_OK);
      add_row(MET_COS, 1023, 0, 65535, 65535, 1, 1, 48'd0, STAT_OK);
      add_row(MET_COS, 10, 11, 3, 4, 0, 0, '0, STAT_OK);
      add_row(MET_COS, 10, 11, 5, 1, 1, 0, '0, STAT_OK);
      // Jaccard of two empty profiles has an empty union.
      add_row(MET_JAC, 12, 13, 0, 0, 1, 1, 48'd0, STAT_ZERO);
      add_row(MET_JAC, 12, 14, 5, 5, 1, 1, 48'd0, STAT_OK);
      add_row(MET_JAC, 15, 16, 4, 0, 0, 0, '0, STAT_OK);
      add_row(MET_JAC, 15, 16, 0, 4, 1, 1, 48'h1_0000, STAT_OK);
      add_row(MET_JAC, 0, 1023, 65535, 1, 1, 0, '0, STAT_OK);
      add_row(MET_L1, 17, 18, 9, 2, 0, 0, '0, STAT_OK);
      add_row(MET_L1, 17, 18, 2, 9, 1, 0, '0, STAT_OK);

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].metric != model_metric)
            set_metric(directed_rows[i].metric);
         send_key(directed_rows[i], draw_gap());
      end

      // Random part over every metric. The first phase runs while the receiver holds off.
      send_random_pairs(MET_L1, 260);
      send_random_pairs(MET_COS, 200);
      send_random_pairs(MET_L2, 200);
      send_random_pairs(MET_JAC, 200);
      send_random_pairs(MET_L1, 80);
      send_random_pairs(MET_COS, 90);
      send_random_pairs(MET_L1, 20);

      req_push <= 1'b0;
      while (pending_pairs.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d keys and %0d pairs: L1 %0d, L2 %0d, cosine %0d, Jaccard %0d",
               keys_sent, pairs_checked, metric_pairs[0], metric_pairs[1], metric_pairs[2],
               metric_pairs[3]);
      $display("status mix: %0d ok, %0d empty denominator, %0d saturated; %0d errors",
               status_seen[0], status_seen[1], status_seen[2], error_count);
      if (error_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
`default_nettype wire
